@@ sv/fvrb_pkg.sv @@
package fvrb_pkg;

    localparam int NUM_COMB    = 8;
    localparam int NUM_AP      = 4;
    localparam int COMB_POS_W  = 11;
    localparam int AP_POS_W    = 10;
    localparam int SAMPLE_W    = 16;

    localparam logic [COMB_POS_W-1:0] COMB_LEN [NUM_COMB] = '{
        11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617
    };
    localparam logic [16:0] COMB_BASE [NUM_COMB] = '{
        17'd0, 17'd1116, 17'd2304, 17'd3581, 17'd4937, 17'd6359, 17'd7850, 17'd9407
    };
    localparam logic [AP_POS_W-1:0] AP_LEN [NUM_AP] = '{
        10'd556, 10'd441, 10'd341, 10'd225
    };
    localparam logic [14:0] AP_BASE [NUM_AP] = '{
        15'd0, 15'd556, 15'd997, 15'd1338
    };

    localparam logic [1:0] REG_FEEDBACK = 2'd0;
    localparam logic [1:0] REG_DAMPING  = 2'd1;
    localparam logic [1:0] REG_DRY      = 2'd2;
    localparam logic [1:0] REG_WET      = 2'd3;

    localparam logic signed [47:0] LIM_POS = 48'sd28000;
    localparam logic signed [47:0] LIM_NEG = -48'sd28000;

    function automatic logic signed [15:0] sat_shift(input logic signed [47:0] v,
                                                     input logic [4:0] s);
        logic signed [47:0] t;
        begin
            t = v >>> s;
            if (t > 48'sd32767)
                sat_shift = 16'sh7fff;
            else if (t < -48'sd32768)
                sat_shift = 16'sh8000;
            else
                sat_shift = t[15:0];
        end
    endfunction

endpackage

@@ sv/fvrb_mac.sv @@
module fvrb_mac (
    input  logic                clk,
    input  logic signed [31:0]  a,
    input  logic signed [16:0]  b,
    input  logic signed [47:0]  acc,
    output logic signed [47:0]  res_reg
);
    logic signed [47:0] prod;

    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        res_reg <= acc + prod;
    end
endmodule

@@ sv/freeverb_reverb_q15.sv @@
// Processing steps from word accepted to word offered: input scaling, then each comb line
// in turn, the allpass input, each allpass stage in turn, and mix and limit; the mix step
// holds while the previous word still waits at the output.
// A new word is taken only once the previous one is through; in_ready is high only while idle.
// After reset a clearing pass zeroes the delay memories; no word is accepted meanwhile.
// Registers reset to their documented defaults.
module freeverb_reverb_q15 #(
    parameter int COMB_TOTAL_LENGTH    = 11024,
    parameter int ALLPASS_TOTAL_LENGTH = 1563
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] in_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample
);
    import fvrb_pkg::*;

    localparam int CW = $clog2(COMB_TOTAL_LENGTH);
    localparam int AW = $clog2(ALLPASS_TOTAL_LENGTH);
    localparam int CLRW = (CW > AW) ? CW : AW;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_R     = 5'd2;
    localparam logic [4:0] S_CRD   = 5'd3;
    localparam logic [4:0] S_CWT   = 5'd4;
    localparam logic [4:0] S_LP1   = 5'd5;
    localparam logic [4:0] S_LP2   = 5'd6;
    localparam logic [4:0] S_FB    = 5'd7;
    localparam logic [4:0] S_CWR   = 5'd8;
    localparam logic [4:0] S_E     = 5'd9;
    localparam logic [4:0] S_EW    = 5'd10;
    localparam logic [4:0] S_ARD   = 5'd11;
    localparam logic [4:0] S_AWT   = 5'd12;
    localparam logic [4:0] S_AWR   = 5'd13;
    localparam logic [4:0] S_DRY   = 5'd14;
    localparam logic [4:0] S_WET1  = 5'd15;
    localparam logic [4:0] S_WET2  = 5'd16;
    localparam logic [4:0] S_MIX   = 5'd17;
    localparam logic [4:0] S_LIM   = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;
    localparam logic [4:0] S_R2    = 5'd20;

    logic [4:0]  state_reg, state_next;
    logic [14:0] fb_reg;
    logic [13:0] damp_reg;
    logic [14:0] dry_reg, wet_reg;

    logic signed [15:0] comb_mem [COMB_TOTAL_LENGTH];
    logic signed [15:0] ap_mem [ALLPASS_TOTAL_LENGTH];
    logic signed [15:0] comb_rd_reg, ap_rd_reg;

    logic [COMB_POS_W-1:0] cpos_reg [NUM_COMB];
    logic signed [15:0]    lp_reg [NUM_COMB];
    logic [AP_POS_W-1:0]   apos_reg [NUM_AP];

    logic [CLRW-1:0]     clr_reg;
    logic [2:0]          k_reg;
    logic signed [15:0]  x_reg, r_reg, v_reg, e_reg, t_reg;
    logic signed [19:0]  sum_reg;
    logic signed [16:0]  w_reg;
    logic signed [15:0]  out_reg;
    logic                out_valid_reg;

    logic signed [31:0]  mac_a;
    logic signed [16:0]  mac_b;
    logic signed [47:0]  mac_acc, mac_res;

    fvrb_mac u_mac (
        .clk     (clk),
        .a       (mac_a),
        .b       (mac_b),
        .acc     (mac_acc),
        .res_reg (mac_res)
    );

    logic [16:0] caddr;
    logic [14:0] aaddr;
    logic        c_ok, a_ok;
    logic        cfg_wr;

    assign caddr  = COMB_BASE[k_reg] + 17'(cpos_reg[k_reg]);
    assign aaddr  = AP_BASE[k_reg[1:0]] + 15'(apos_reg[k_reg[1:0]]);
    assign c_ok   = 32'(caddr) < 32'(COMB_TOTAL_LENGTH);
    assign a_ok   = 32'(aaddr) < 32'(ALLPASS_TOTAL_LENGTH);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FEEDBACK: prdata = 32'(fb_reg);
            REG_DAMPING:  prdata = 32'(damp_reg);
            REG_DRY:      prdata = 32'(dry_reg);
            REG_WET:      prdata = 32'(wet_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg   <= 15'd27524;
            damp_reg <= 14'd6553;
            dry_reg  <= 15'd32767;
            wet_reg  <= 15'd32767;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FEEDBACK: fb_reg   <= pwdata[14:0];
                REG_DAMPING:  damp_reg <= pwdata[13:0];
                REG_DRY:      dry_reg  <= pwdata[14:0];
                REG_WET:      wet_reg  <= pwdata[14:0];
                default:      ;
            endcase
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        mac_a   = '0;
        mac_b   = '0;
        mac_acc = '0;
        unique case (state_reg)
            S_R:    begin mac_a = 32'(x_reg); mac_b = 17'sd8738; end
            S_LP1:  begin mac_a = 32'(v_reg); mac_b = 17'sd32768 - 17'(damp_reg); end
            S_LP2:  begin mac_a = 32'(lp_reg[k_reg]); mac_b = 17'(damp_reg);
                          mac_acc = mac_res; end
            S_FB:   begin mac_a = 32'(sat_shift(mac_res, 5'd15)); mac_b = 17'(fb_reg); end
            S_E:    begin mac_a = 32'(sum_reg); mac_b = 17'sd31457; end
            S_DRY:  begin mac_a = 32'(x_reg); mac_b = 17'(dry_reg); end
            S_WET1: begin mac_a = 32'(e_reg) * 32'sd30; mac_b = 17'(wet_reg); end
            S_LIM:  begin
                        mac_a = (w_reg > 17'sd28000) ? 32'(w_reg) - 32'sd28000
                                                     : 32'(w_reg) + 32'sd28000;
                        mac_b = 17'sd7151;
                    end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (32'(clr_reg) >= 32'(COMB_TOTAL_LENGTH) - 1
                        && 32'(clr_reg) >= 32'(ALLPASS_TOTAL_LENGTH) - 1)
                        state_next = S_IDLE;
            S_IDLE: if (in_valid) state_next = S_R;
            S_R:    state_next = S_R2;
            S_R2:   state_next = S_CRD;
            S_CRD:  state_next = S_CWT;
            S_CWT:  state_next = S_LP1;
            S_LP1:  state_next = S_LP2;
            S_LP2:  state_next = S_FB;
            S_FB:   state_next = S_CWR;
            S_CWR:  state_next = (k_reg == 3'd7) ? S_E : S_CRD;
            S_E:    state_next = S_EW;
            S_EW:   state_next = S_ARD;
            S_ARD:  state_next = S_AWT;
            S_AWT:  state_next = S_AWR;
            S_AWR:  state_next = (k_reg == 3'd3) ? S_DRY : S_ARD;
            S_DRY:  state_next = S_WET1;
            S_WET1: state_next = S_WET2;
            S_WET2: state_next = S_MIX;
            S_MIX:  state_next = (out_valid_reg && !out_ready) ? S_MIX : S_LIM;
            S_LIM:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COMB; i++)
            begin
                cpos_reg[i] <= '0;
                lp_reg[i]   <= '0;
            end
            for (int i = 0; i < NUM_AP; i++)
                apos_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:  clr_reg <= clr_reg + 1'b1;
                S_IDLE: if (in_valid)
                        begin
                            x_reg   <= in_sample;
                            k_reg   <= '0;
                            sum_reg <= '0;
                        end
                S_R2:   r_reg <= sat_shift(mac_res, 5'd17);
                S_CWT:  begin
                            v_reg   <= c_ok ? comb_rd_reg : 16'sd0;
                            sum_reg <= sum_reg + 20'(c_ok ? comb_rd_reg : 16'sd0);
                        end
                S_FB:   lp_reg[k_reg] <= sat_shift(mac_res, 5'd15);
                S_CWR:  begin
                            cpos_reg[k_reg] <= (cpos_reg[k_reg] + 1'b1 >= COMB_LEN[k_reg])
                                               ? '0 : cpos_reg[k_reg] + 1'b1;
                            k_reg <= k_reg + 1'b1;
                        end
                S_EW:   begin
                            e_reg <= sat_shift(mac_res, 5'd17);
                            k_reg <= '0;
                        end
                S_AWT:  v_reg <= a_ok ? ap_rd_reg : 16'sd0;
                S_AWR:  begin
                            e_reg <= sat_shift(48'(v_reg) - 48'(e_reg), 5'd1);
                            apos_reg[k_reg[1:0]] <=
                                (apos_reg[k_reg[1:0]] + 1'b1 >= AP_LEN[k_reg[1:0]])
                                ? '0 : apos_reg[k_reg[1:0]] + 1'b1;
                            k_reg <= k_reg + 1'b1;
                        end
                S_WET1: w_reg <= 17'(sat_shift(mac_res, 5'd15));
                S_WET2: w_reg <= w_reg + 17'(sat_shift(mac_res, 5'd15));
                S_MIX:  ;
                S_OUT:  begin
                            if (w_reg > 17'sd28000 || w_reg < -17'sd28000)
                                out_reg <= sat_shift(
                                    (w_reg > 17'sd28000 ? LIM_POS : LIM_NEG)
                                    + (mac_res >>> 16), 5'd0);
                            else
                                out_reg <= w_reg[15:0];
                            out_valid_reg <= 1'b1;
                        end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        t_reg = sat_shift(48'(r_reg) + 48'(sat_shift(mac_res, 5'd15)), 5'd0);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
        begin
            if (32'(clr_reg) < 32'(COMB_TOTAL_LENGTH))
                comb_mem[clr_reg[CW-1:0]] <= '0;
        end
        else if (state_reg == S_CWR && c_ok)
            comb_mem[caddr[CW-1:0]] <= t_reg;
        if (state_reg == S_CRD)
            comb_rd_reg <= comb_mem[caddr[CW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
        begin
            if (32'(clr_reg) < 32'(ALLPASS_TOTAL_LENGTH))
                ap_mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (state_reg == S_AWR && a_ok)
            ap_mem[aaddr[AW-1:0]] <= sat_shift(48'(e_reg) + 48'(v_reg >>> 1), 5'd0);
        if (state_reg == S_ARD)
            ap_rd_reg <= ap_mem[aaddr[AW-1:0]];
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;
endmodule

@@ tb/freeverb_reverb_q15_tb.sv @@
module freeverb_reverb_q15_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fvrb_pkg::*;

    localparam int COMB_SIZE = 11024;
    localparam int AP_SIZE   = 1563;
    localparam int N_RANDOM  = 1150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] in_sample = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] out_sample;

    freeverb_reverb_q15 u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
        .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample)
    );

    always #5 clk = ~clk;

    // reverb state mirror
    logic [14:0] fb_gain;
    logic [13:0] damp;
    logic [14:0] dry_g;
    logic [14:0] wet_g;
    logic signed [15:0] comb_mem [COMB_SIZE];
    logic signed [15:0] ap_mem [AP_SIZE];
    int unsigned comb_pos [NUM_COMB];
    logic signed [15:0] comb_lp [NUM_COMB];
    int unsigned ap_pos [NUM_AP];

    logic signed [15:0] pending_samples [$];
    logic signed [15:0] expected_samples [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int words_in = 0;
    int words_out = 0;
    bit hold_sender = 1'b0;
    bit in_taken = 1'b0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v, int s);
        longint t;
        t = v >>> s;
        if (t > 32767)
            return 32767;
        if (t < -32768)
            return -32768;
        return t;
    endfunction

    task automatic reset_mirror();
        fb_gain = 15'd27524;
        damp = 14'd6553;
        dry_g = 15'd32767;
        wet_g = 15'd32767;
        foreach (comb_mem[i]) comb_mem[i] = '0;
        foreach (ap_mem[i]) ap_mem[i] = '0;
        foreach (comb_pos[i]) begin comb_pos[i] = 0; comb_lp[i] = '0; end
        foreach (ap_pos[i]) ap_pos[i] = 0;
    endtask

    function automatic logic signed [15:0] reverb_sample(logic signed [15:0] x);
        longint r, sum, e, v, lp, w;
        int unsigned base, addr;
        r = clip16(longint'(x) * 8738, 17);
        sum = 0;
        base = 0;
        for (int k = 0; k < NUM_COMB; k++) begin
            addr = base + comb_pos[k];
            v = (addr < COMB_SIZE) ? longint'(comb_mem[addr]) : 0;
            sum += v;
            lp = clip16(v * (32768 - longint'(damp)) + longint'(comb_lp[k]) * longint'(damp), 15);
            comb_lp[k] = lp[15:0];
            if (addr < COMB_SIZE)
                comb_mem[addr] = clip16(r + clip16(lp * longint'(fb_gain), 15), 0);
            comb_pos[k] = (comb_pos[k] + 1 >= COMB_LEN[k]) ? 0 : comb_pos[k] + 1;
            base += COMB_LEN[k];
        end
        e = clip16(sum * 31457, 17);
        base = 0;
        for (int k = 0; k < NUM_AP; k++) begin
            addr = base + ap_pos[k];
            v = (addr < AP_SIZE) ? longint'(ap_mem[addr]) : 0;
            if (addr < AP_SIZE)
                ap_mem[addr] = clip16(e + floor_sh(v, 1), 0);
            e = clip16(v - e, 1);
            ap_pos[k] = (ap_pos[k] + 1 >= AP_LEN[k]) ? 0 : ap_pos[k] + 1;
            base += AP_LEN[k];
        end
        w = clip16(longint'(x) * longint'(dry_g), 15) + clip16(e * 30 * longint'(wet_g), 15);
        if (w > 28000)
            w = 28000 + floor_sh((w - 28000) * 7151, 16);
        else if (w < -28000)
            w = -28000 + floor_sh((w + 28000) * 7151, 16);
        if (w > 32767)
            w = 32767;
        if (w < -32768)
            w = -32768;
        return w[15:0];
    endfunction

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                in_valid <= 1'b0;
                if (pending_samples.size() > 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct) begin
                    in_sample <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                end
            end
            else if (!in_valid && pending_samples.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct) begin
                in_sample <= pending_samples.pop_front();
                in_valid <= 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    logic signed [15:0] want;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_samples.push_back(reverb_sample(in_sample));
                words_in++;
                in_taken = 1'b1;
            end
            if (out_valid && out_ready) begin
                words_out++;
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word out_sample=%0d", out_sample);
                end
                else begin
                    want = expected_samples.pop_front();
                    if (out_sample !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: out_sample expected %0d got %0d",
                                     words_out, want, out_sample);
                    end
                end
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_FEEDBACK: fb_gain = val[14:0];
            REG_DAMPING:  damp = val[13:0];
            REG_DRY:      dry_g = val[14:0];
            default:      wet_g = val[14:0];
        endcase
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !in_valid && expected_samples.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_gains(logic [31:0] fb, logic [31:0] dm, logic [31:0] dr,
                             logic [31:0] wt);
        apb_write(REG_FEEDBACK, fb);
        apb_write(REG_DAMPING, dm);
        apb_write(REG_DRY, dr);
        apb_write(REG_WET, wt);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $urandom_range(200) - 100;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        reset_mirror();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, silence, impulses
        foreach (pending_samples[i]) ;
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'sh0001);
        pending_samples.push_back(-16'sh0001);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shaaaa);
        for (int i = 0; i < 6; i++) pending_samples.push_back(16'sh7fff);
        for (int i = 0; i < 6; i++) pending_samples.push_back(16'sh8000);
        drain();

        // extremes of every register, damping at the top of its range too
        set_gains(32'h7fff, 32'h3fff, 32'h7fff, 32'h7fff);
        for (int i = 0; i < 20; i++) pending_samples.push_back(i[0] ? 16'sh7fff : 16'sh8000);
        drain();
        set_gains(32'd22937, 32'd0, 32'd0, 32'd32767);
        for (int i = 0; i < 10; i++) pending_samples.push_back(rand_sample());
        drain();

        send_idle_pct = 37; recv_idle_pct = 77;
        set_gains(32'd32112, 32'd13107, 32'd32767, 32'd0);
        for (int i = 0; i < N_RANDOM / 3; i++) pending_samples.push_back(rand_sample());
        wait (pending_samples.size() == 200);
        hold_sender = 1'b1;
        wait (!in_valid && expected_samples.size() == 0);
        hold_sender = 1'b0;
        drain();

        send_idle_pct = 77; recv_idle_pct = 37;
        set_gains($urandom_range(32767), $urandom_range(16383),
                  $urandom_range(32767), $urandom_range(32767));
        for (int i = 0; i < N_RANDOM / 3; i++) pending_samples.push_back(rand_sample());
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        set_gains(32'd27524, 32'd6553, 32'd16384, 32'd32767);
        for (int i = 0; i < N_RANDOM / 3; i++) pending_samples.push_back(rand_sample());
        drain();

        $display("reverb run: %0d samples in, %0d out, six register settings incl. limits",
                 words_in, words_out);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("freeverb_reverb_q15_tb OK");
        else
            $display("freeverb_reverb_q15_tb NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("freeverb_reverb_q15_tb NOT OK");
        $finish;
    end
endmodule
